// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL. In synthesis they expand to nothing.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check cons in the same cycle whenever ante holds.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check cons in the next cycle whenever ante holds.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: rtl/ale_pkg.sv
// ---------------------------------------------------------------------------
// ale_pkg
// Types, codes and defaults for the array list engine.
// ---------------------------------------------------------------------------
package ale_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;

  localparam int unsigned ACT_W   = 3;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned ENTRY_W = 11;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SET    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FIND   = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] operand_value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [STAT_W-1:0]        status;
    logic [ENTRY_W-1:0]       entry_count;
  } res_t;

endpackage

// File: rtl/ale_ram.sv
// ---------------------------------------------------------------------------
// ale_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module ale_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/array_list_engine.sv
// ---------------------------------------------------------------------------
// array_list_engine
// Packed list of signed 32-bit words with push, pop, remove, get, set, find.
// ---------------------------------------------------------------------------
//
//  channel  | signals               | handshake
//  ---------+-----------------------+------------------------------------------
//  command  | cmd (cmd_t)           | beat taken on start && !busy
//  result   | result (res_t)        | beat shown for one cycle with done high
//
//  Push, set, an action refused at its checks and an unused code: the result
//  beat comes in the cycle after the command. Pop and get go through S_READ
//  for one RAM read first. Find reads from slot 0 until a match or the end;
//  remove shifts every word above position down one slot. Scans walk the
//  list one RAM read per cycle, so the single RAM read port sets the rate.
//  Reset clears the count and the sequencer; the RAM needs no clearing.
//  The result beat cannot be stalled; a new command may start in its cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module array_list_engine
  import ale_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output res_t result
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FIND,
    S_REMOVE
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;    // live entries
  logic [CNT_W-1:0]   idx, idx_next;        // next address to read in a scan
  logic               pend, pend_next;      // a scan read is in flight
  logic [ADDR_W-1:0]  pend_idx, pend_idx_next;
  cmd_t               op, op_next;          // command held during a scan
  logic               done_next;
  res_t               res_next;

  logic               accept;
  logic               pos_ok;
  logic               is_full;
  logic               hit;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign pos_ok  = 32'(cmd.position) < 32'(count);
  assign is_full = (count == CNT_W'(CAPACITY));
  // compare the word read last cycle against the search key
  assign hit     = pend && (ram_rdata == op.operand_value);

  ale_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM port control: commands drive it directly when idle, the scan
  // counters drive it during find and remove.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(cmd.position);
    ram_wdata = cmd.operand_value;
    ram_raddr = idx[ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        if (cmd.action == ACT_POP) begin
          ram_raddr = ADDR_W'(count - CNT_W'(1));
        end else begin
          ram_raddr = ADDR_W'(cmd.position);
        end
        if (accept && cmd.action == ACT_PUSH && !is_full) begin
          ram_we    = 1'b1;
          ram_waddr = count[ADDR_W-1:0];
        end
        if (accept && cmd.action == ACT_SET && pos_ok) begin
          ram_we = 1'b1;
        end
      end
      S_REMOVE: begin
        // shift down: the word read last cycle lands one slot lower
        ram_we    = pend;
        ram_waddr = pend_idx - ADDR_W'(1);
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    pend_next     = pend;
    pend_idx_next = pend_idx;
    op_next       = op;
    done_next     = 1'b0;
    res_next      = result;

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next                 = cmd;
          res_next.read_value     = '0;
          res_next.found_position = '0;
          res_next.status         = ST_OK;
          case (cmd.action)
            ACT_PUSH: begin
              done_next = 1'b1;
              if (is_full) begin
                res_next.status = ST_FULL;
              end else begin
                count_next = count + CNT_W'(1);
              end
            end
            ACT_POP: begin
              if (count == '0) begin
                done_next       = 1'b1;
                res_next.status = ST_EMPTY;
              end else begin
                state_next = S_READ;
              end
            end
            ACT_GET: begin
              if (!pos_ok) begin
                done_next       = 1'b1;
                res_next.status = ST_RANGE;
              end else begin
                state_next = S_READ;
              end
            end
            ACT_SET: begin
              done_next = 1'b1;
              if (!pos_ok) begin
                res_next.status = ST_RANGE;
              end
            end
            ACT_FIND: begin
              state_next = S_FIND;
              idx_next   = '0;
              pend_next  = 1'b0;
            end
            ACT_REMOVE: begin
              if (!pos_ok) begin
                done_next       = 1'b1;
                res_next.status = ST_RANGE;
              end else begin
                state_next = S_REMOVE;
                idx_next   = CNT_W'(cmd.position) + CNT_W'(1);
                pend_next  = 1'b0;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        done_next           = 1'b1;
        res_next.read_value = ram_rdata;
        state_next          = S_IDLE;
        if (op.action == ACT_POP) begin
          count_next = count - CNT_W'(1);
        end
      end

      S_FIND: begin
        if (hit) begin
          done_next               = 1'b1;
          res_next.found_position = POS_W'(pend_idx);
          state_next              = S_IDLE;
          pend_next               = 1'b0;
        end else if (idx >= count) begin
          done_next       = 1'b1;
          res_next.status = ST_NOTFOUND;
          state_next      = S_IDLE;
          pend_next       = 1'b0;
        end else begin
          pend_next     = 1'b1;
          pend_idx_next = idx[ADDR_W-1:0];
          idx_next      = idx + CNT_W'(1);
        end
      end

      S_REMOVE: begin
        if (idx < count) begin
          pend_next     = 1'b1;
          pend_idx_next = idx[ADDR_W-1:0];
          idx_next      = idx + CNT_W'(1);
        end else begin
          // last shifted word is written this cycle
          done_next  = 1'b1;
          count_next = count - CNT_W'(1);
          state_next = S_IDLE;
          pend_next  = 1'b0;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    res_next.entry_count = ENTRY_W'(count_next);
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      done  <= done_next;
    end
    idx      <= idx_next;
    pend_idx <= pend_idx_next;
    op       <= op_next;
    result   <= res_next;
  end

  // A successful push grows the list by one and answers in the next cycle.
  `ASSERT_NEXT(a_push_grows, clk, rst, accept && cmd.action == ACT_PUSH && !is_full, done && count == $past(count) + CNT_W'(1), "push did not grow the list")
  // A full report only comes from a list at capacity.
  `ASSERT_IMPLIES(a_full_at_cap, clk, rst, done && result.status == ST_FULL, is_full, "full reported below capacity")
  // A failed action leaves the count alone.
  `ASSERT_IMPLIES(a_err_keeps_count, clk, rst, done && result.status != ST_OK, count == $past(count), "failed action changed the count")
  // The scan index never runs past the count of live entries.
  `ASSERT_IMPLIES(a_scan_in_range, clk, rst, state == S_FIND || state == S_REMOVE, idx <= count, "scan index ran past the count")

endmodule
